/* sv/ipv4tp_pkg.sv */
// ipv4tp_pkg: types and character codes for the ipv4 text line parser
// no dependencies; imported by ipv4tp_line_core, ipv4_text_line_parser_unit, ipv4tp_line_checker and the testbench
package ipv4tp_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [8:0] VALUE_SAT  = 9'd256;
  localparam logic [2:0] PART_COUNT = 3'd4;

  // octet phase codes
  localparam logic [1:0] PH_BLANK = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       stream_end;
  } req_item_t;

  typedef struct packed {
    logic        line_valid;
    logic [31:0] address;
  } rsp_item_t;

  typedef struct packed {
    logic      emit;
    rsp_item_t item;
  } core_res_t;

endpackage

/* sv/ipv4tp_line_core.sv */
// ipv4tp_line_core: per-line parse state and the per-byte update logic
// depends on ipv4tp_pkg; result is combinational for the caller to register
module ipv4tp_line_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  ipv4tp_pkg::req_item_t req,
  output ipv4tp_pkg::core_res_t res
);
  import ipv4tp_pkg::*;

  logic       in_address_field, in_address_field_next;
  logic [2:0] separator_count, separator_count_next;
  logic [1:0] octet_phase, octet_phase_next;
  logic       octet_negative, octet_negative_next;
  logic [8:0] octet_value, octet_value_next;
  logic       line_bad, line_bad_next;
  logic [7:0] octet_store [3];

  logic        is_nl, is_digit, is_blank, is_sign, store_we, close_line;
  logic        cur_ok, next_ok;
  logic [11:0] acc;
  logic [1:0]  store_idx;
  logic [7:0]  third_octet;

  assign is_nl    = (req.char_byte == CH_NL);
  assign is_digit = (req.char_byte >= CH_ZERO) && (req.char_byte <= CH_NINE);
  assign is_blank = (req.char_byte == CH_SPACE) || (req.char_byte == CH_VT) ||
                    (req.char_byte == CH_FF) || (req.char_byte == CH_CR);
  assign is_sign  = (req.char_byte == CH_PLUS) || (req.char_byte == CH_MINUS);
  assign acc      = ({3'd0, octet_value} * 12'd10) + {4'd0, req.char_byte - CH_ZERO};
  assign cur_ok   = (octet_value <= OCTET_MAX) && !(octet_negative && (octet_value != 9'd0));
  assign store_idx = separator_count[1:0];

  // byte effect on the line state, skipped for a newline and for bytes after the tab
  always_comb begin
    in_address_field_next = in_address_field;
    separator_count_next  = separator_count;
    octet_phase_next      = octet_phase;
    octet_negative_next   = octet_negative;
    octet_value_next      = octet_value;
    line_bad_next         = line_bad;
    store_we              = 1'b0;
    if (!is_nl && in_address_field) begin
      priority if (req.char_byte == CH_TAB) begin
        in_address_field_next = 1'b0;
      end else if (req.char_byte == CH_DOT) begin
        if (!cur_ok) line_bad_next = 1'b1;
        store_we = (separator_count < PART_COUNT - 3'd1);
        if (separator_count < PART_COUNT) separator_count_next = separator_count + 3'd1;
        octet_phase_next    = PH_BLANK;
        octet_negative_next = 1'b0;
        octet_value_next    = 9'd0;
      end else if (is_digit) begin
        if (octet_phase != PH_DONE) begin
          octet_value_next = (acc > {3'd0, VALUE_SAT}) ? VALUE_SAT : acc[8:0];
          octet_phase_next = PH_DIGIT;
        end
      end else if (octet_phase == PH_BLANK && is_blank) begin
        octet_phase_next = octet_phase;
      end else if (octet_phase == PH_BLANK && is_sign) begin
        octet_negative_next = (req.char_byte == CH_MINUS);
        octet_phase_next    = PH_SIGN;
      end else begin
        octet_phase_next = PH_DONE;
      end
    end
  end

  assign close_line = is_nl || req.stream_end;
  assign next_ok    = (separator_count_next == PART_COUNT - 3'd1) && !line_bad_next &&
                      (octet_value_next <= OCTET_MAX) &&
                      !(octet_negative_next && (octet_value_next != 9'd0));

  // a closing third dot writes the last stored octet in this same byte
  assign third_octet = store_we ? octet_value[7:0] : octet_store[2];

  always_comb begin
    res.emit            = fire && close_line;
    res.item.line_valid = next_ok;
    res.item.address    = next_ok ? {octet_store[0], octet_store[1], third_octet,
                                     octet_value_next[7:0]} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_address_field <= 1'b1;
      separator_count  <= 3'd0;
      octet_phase      <= PH_BLANK;
      octet_negative   <= 1'b0;
      octet_value      <= 9'd0;
      line_bad         <= 1'b0;
    end else if (fire) begin
      if (close_line) begin
        in_address_field <= 1'b1;
        separator_count  <= 3'd0;
        octet_phase      <= PH_BLANK;
        octet_negative   <= 1'b0;
        octet_value      <= 9'd0;
        line_bad         <= 1'b0;
      end else begin
        in_address_field <= in_address_field_next;
        separator_count  <= separator_count_next;
        octet_phase      <= octet_phase_next;
        octet_negative   <= octet_negative_next;
        octet_value      <= octet_value_next;
        line_bad         <= line_bad_next;
      end
    end
  end

  // octet store has no reset; entries are read only after being written this line
  always_ff @(posedge clk) begin
    if (fire && store_we) octet_store[store_idx] <= octet_value[7:0];
  end

endmodule

/* sv/ipv4_text_line_parser_unit.sv */
// ipv4_text_line_parser_unit: top level, input register, parse core, result register
// depends on ipv4tp_pkg and ipv4tp_line_core
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_data (char_byte, stream_end)
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_data (line_valid, address)
//
// one byte per cycle sustained while the result is not stalled; a byte is held in the input register,
// and its result, if it closes a line, is loaded into the result register when that byte fires
// the state update runs in the input-register stage, so a stalled result holds that stage
// reset (rst, synchronous) empties both registers and clears the line state
// req_stall rises only when the input register is full and the result is stalled
module ipv4_text_line_parser_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  ipv4tp_pkg::req_item_t req_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output ipv4tp_pkg::rsp_item_t rsp_data
);
  import ipv4tp_pkg::*;

  logic      in_full;
  req_item_t in_item;
  logic      advance, fire;
  core_res_t core_res;

  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = in_full && advance;
  assign req_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!req_stall) begin
      in_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) in_item <= req_data;
  end

  ipv4tp_line_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= core_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res.emit) rsp_data <= core_res.item;
  end

  a_bad_line_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.line_valid |-> rsp_data.address == 32'd0)
    else $error("invalid line result carries a nonzero address");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    in_full && rsp_valid && rsp_stall |=> in_full)
    else $error("input stage dropped a byte while the result was stalled");

  a_newline_emits: assert property (@(posedge clk) disable iff (rst)
    fire && in_item.char_byte == CH_NL |=> rsp_valid)
    else $error("newline did not produce a result");

endmodule

/* dv/ipv4tp_line_checker.sv */
// ipv4tp_line_checker: watches both channels of the ipv4 text line parser, predicts
// each line result from the accepted bytes and compares it with the block's output
// depends on ipv4tp_pkg
`timescale 1ns / 1ps

module ipv4tp_line_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  ipv4tp_pkg::req_item_t req_data,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  ipv4tp_pkg::rsp_item_t rsp_data,
  output int                    mismatch_count,
  output int                    lines_open
);

  import ipv4tp_pkg::*;

  // predicted parse state of the current line
  logic       before_tab;
  logic [2:0] dot_count;
  logic [1:0] part_phase;
  logic       part_negative;
  logic [8:0] part_value;
  logic [7:0] octet_hold [3];
  logic       line_rejected;

  rsp_item_t  predicted_lines [$];

  initial begin
    mismatch_count = 0;
    lines_open     = 0;
  end

  function automatic logic part_in_range(input logic [8:0] val, input logic neg);
    return (val <= OCTET_MAX) && !(neg && val != 9'd0);
  endfunction

  task automatic start_part();
    part_phase    = PH_BLANK;
    part_negative = 1'b0;
    part_value    = 9'd0;
  endtask

  task automatic start_line();
    before_tab    = 1'b1;
    dot_count     = 3'd0;
    line_rejected = 1'b0;
    start_part();
  endtask

  task automatic close_line();
    rsp_item_t res;
    res.line_valid = (dot_count == PART_COUNT - 3'd1) && !line_rejected &&
                     part_in_range(part_value, part_negative);
    res.address    = res.line_valid ?
                     {octet_hold[0], octet_hold[1], octet_hold[2], part_value[7:0]} : 32'd0;
    predicted_lines = {predicted_lines, res};
    start_line();
  endtask

  task automatic parse_text_byte(input logic [7:0] c);
    int acc;
    if (!before_tab) return;
    if (c == CH_TAB) begin
      before_tab = 1'b0;
    end else if (c == CH_DOT) begin
      if (!part_in_range(part_value, part_negative)) line_rejected = 1'b1;
      if (dot_count < PART_COUNT - 3'd1) octet_hold[dot_count[1:0]] = part_value[7:0];
      if (dot_count < PART_COUNT) dot_count = dot_count + 3'd1;
      start_part();
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (part_phase != PH_DONE) begin
        acc = int'(part_value) * 10 + int'(c - CH_ZERO);
        // digit value sticks at 256 so it can never wrap back into range
        part_value = (acc > int'(VALUE_SAT)) ? VALUE_SAT : acc[8:0];
        part_phase = PH_DIGIT;
      end
    end else if (part_phase == PH_BLANK &&
                 (c == CH_SPACE || c == CH_VT || c == CH_FF || c == CH_CR)) begin
      // leading blank, skipped
    end else if (part_phase == PH_BLANK && (c == CH_PLUS || c == CH_MINUS)) begin
      part_negative = (c == CH_MINUS);
      part_phase    = PH_SIGN;
    end else begin
      part_phase = PH_DONE;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      predicted_lines.delete();
      octet_hold = '{8'd0, 8'd0, 8'd0};
      start_line();
    end else begin
      if (req_valid && !req_stall) begin
        if (req_data.char_byte == CH_NL) begin
          close_line();
        end else begin
          parse_text_byte(req_data.char_byte);
          if (req_data.stream_end) close_line();
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (predicted_lines.size() == 0) begin
          $display("%0t: unexpected line result, expected none, actual valid=%0b address=%08h",
                   $time, rsp_data.line_valid, rsp_data.address);
          mismatch_count++;
        end else begin
          if (rsp_data.line_valid !== predicted_lines[0].line_valid) begin
            $display("%0t: line_valid mismatch, expected %0b, actual %0b",
                     $time, predicted_lines[0].line_valid, rsp_data.line_valid);
            mismatch_count++;
          end
          if (rsp_data.address !== predicted_lines[0].address) begin
            $display("%0t: address mismatch, expected %08h, actual %08h",
                     $time, predicted_lines[0].address, rsp_data.address);
            mismatch_count++;
          end
          void'(predicted_lines.pop_front());
        end
      end
    end
    lines_open = predicted_lines.size();
  end

endmodule

/* dv/tb_ipv4_text_line_parser_unit.sv */
// tb_ipv4_text_line_parser_unit: drives text bytes into the ipv4 text line parser with
// random idling and stalls, and gives the verdict from the line checker's count
// depends on ipv4tp_pkg, ipv4_text_line_parser_unit and ipv4tp_line_checker
`timescale 1ns / 1ps

module tb_ipv4_text_line_parser_unit;

  import ipv4tp_pkg::*;

  localparam int STREAM_BYTES = 1100;
  localparam int STALL_LIMIT  = 2000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req_data  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp_data;

  int        mismatch_count;
  int        lines_open;
  int        sent_count     = 0;
  int        holdoff_left   = 0;
  logic      holdoff_done   = 1'b0;
  int        quiet_cycles   = 0;

  req_item_t text_stream [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipv4_text_line_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  ipv4tp_line_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_data       (req_data),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp_data       (rsp_data),
    .mismatch_count (mismatch_count),
    .lines_open     (lines_open)
  );

  task automatic push_char(input logic [7:0] c, input logic last = 1'b0);
    req_item_t it;
    it.char_byte  = c;
    it.stream_end = last;
    text_stream = {text_stream, it};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // mostly dotted quads with random content; some noise, short or long lines
  task automatic add_random_line();
    int        parts;
    int        roll;
    req_item_t tail;
    logic [7:0] blanks [4];
    blanks = '{CH_SPACE, CH_VT, CH_FF, CH_CR};
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(255)), $urandom_range(19) == 0);
      return;
    end
    roll  = $urandom_range(99);
    parts = (roll < 8) ? 3 : (roll < 16) ? 5 : 4;
    for (int p = 0; p < parts; p++) begin
      if (p != 0) push_char(CH_DOT);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) push_char(blanks[2'($urandom_range(3))]);
      end
      roll = $urandom_range(99);
      if (roll < 5) push_char(CH_MINUS);
      else if (roll < 10) push_char(CH_PLUS);
      roll = $urandom_range(99);
      if (roll < 5) begin
        // empty part
      end else if (roll < 12) begin
        push_text($sformatf("%0d", $urandom_range(99999, 256)));
      end else if (roll < 17) begin
        push_text($sformatf("%03d", $urandom_range(255)));
      end else begin
        push_text($sformatf("%0d", $urandom_range(255)));
      end
      if ($urandom_range(99) < 4) push_char(8'($urandom_range(8'h7e, 8'h21)));
    end
    if ($urandom_range(99) < 10) begin
      push_char(CH_TAB);
      repeat ($urandom_range(5)) push_char(8'($urandom_range(8'h7e, 8'h20)));
    end
    roll = $urandom_range(99);
    if (roll < 85) begin
      push_char(CH_NL);
    end else if (roll < 92) begin
      push_char(CH_NL, 1'b1);
    end else begin
      // close on the last byte of the line itself
      tail = text_stream.pop_back();
      tail.stream_end = 1'b1;
      text_stream = {text_stream, tail};
    end
  endtask

  // result side: random stalls, a calm stretch and one long hold-off
  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      rsp_stall    <= 1'b1;
    end else if (!holdoff_done && sent_count >= 700) begin
      holdoff_done <= 1'b1;
      holdoff_left <= 300;
      rsp_stall    <= 1'b1;
    end else if (sent_count >= 300 && sent_count < 500) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int next_byte;
    next_byte = 0;

    // extremes, minus zero, bare sign, oversize, empty part, tab, short line,
    // top byte closing the stream, newline closing the stream
    push_text("255.-0.+.9\n");
    push_text("256.1..\t\n");
    push_text("-1.2");
    push_char(8'hFF, 1'b1);
    push_char(CH_NL, 1'b1);
    while (text_stream.size() < STREAM_BYTES) add_random_line();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (next_byte < text_stream.size()) begin
      @(posedge clk);
      if (req_valid && !req_stall) begin
        next_byte++;
        sent_count <= next_byte;
      end
      if (req_valid && req_stall) begin
        // held request stays as it is
      end else if (next_byte < text_stream.size() &&
                   ((next_byte >= 300 && next_byte < 500) || $urandom_range(99) >= 12)) begin
        req_valid <= 1'b1;
        req_data  <= text_stream[next_byte];
      end else begin
        req_valid <= 1'b0;
      end
    end

    do @(negedge clk); while (lines_open != 0);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && lines_open == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
